@@ rtl/fpdda_pkg.sv @@
package fpdda_pkg;

   localparam int ADDR_BITS  = 20;
   localparam int COLOR_BITS = 8;
   localparam int PITCH_BITS = 11;

   localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(1);

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic line_active;
   } status_type;

endpackage

@@ rtl/fpdda_ctrl.sv @@
module fpdda_ctrl #(
   parameter int FRAC_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_action,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  fpdda_pkg::status_type   status,
   output fpdda_pkg::ctrl_cmd_type cmd
);
   import fpdda_pkg::*;

   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                valid_ff, valid_in;
   logic                accept;

   assign req_tready = (state_ff == ST_IDLE) && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd.load     = accept && (req_action == ACTION_START);
      cmd.emit     = accept && (req_action == ACTION_STEP) && status.line_active;
      cmd.div_step = (state_ff == ST_DIVIDE);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_DIVIDE;
               cnt_in   = '0;
            end
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   a_no_request_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> !req_tready)
      else $error("request taken during division");

   a_load_starts_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_DIVIDE) && (cnt_ff == '0))
      else $error("start request did not begin division");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("pixel lost after step request");

   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) && (cnt_ff == CNT_LAST) |=> (state_ff == ST_IDLE))
      else $error("division overran its iteration count");

   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!valid_ff || rsp_tready))
      else $error("pixel overwrote an undelivered one");

endmodule

@@ rtl/fpdda_datapath.sv @@
module fpdda_datapath #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fpdda_pkg::ctrl_cmd_type              cmd,
   input  logic [COORD_BITS-1:0]                x_start,
   input  logic [COORD_BITS-1:0]                y_start,
   input  logic [COORD_BITS-1:0]                x_end,
   input  logic [COORD_BITS-1:0]                y_end,
   input  logic [fpdda_pkg::COLOR_BITS-1:0]     color,
   input  logic [fpdda_pkg::PITCH_BITS-1:0]     row_pitch,
   output fpdda_pkg::status_type                status,
   output logic [fpdda_pkg::ADDR_BITS-1:0]      pixel_address,
   output logic [fpdda_pkg::COLOR_BITS-1:0]     pixel_color,
   output logic                                 last_pixel
);
   import fpdda_pkg::*;

   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 2;
   localparam int STEP_BITS = FRAC_BITS + 2;
   localparam int FLR_BITS  = COORD_BITS + 2;

   // start request decode
   logic [COORD_BITS:0]   dx, dy;
   logic [COORD_BITS-1:0] adx, ady;
   logic                  major_x;
   logic [COORD_BITS:0]   len, minor_mag;

   // line state
   logic [ACC_BITS-1:0]   acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [COORD_BITS:0]   left_ff, left_in;
   logic [PITCH_BITS-1:0] pitch_ff, pitch_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  major_x_ff, major_x_in;
   logic                  major_neg_ff, major_neg_in;
   logic                  minor_neg_ff, minor_neg_in;

   // serial divider
   logic [COORD_BITS:0]   den_ff, den_in;
   logic [COORD_BITS+1:0] rem_ff, rem_in, rem_sub;
   logic [FRAC_BITS:0]    quo_ff, quo_in;
   logic                  rem_ge;

   logic [STEP_BITS-1:0]  major_step, minor_step, step_x, step_y;
   logic [FLR_BITS-1:0]   fx, fy;
   logic [ADDR_BITS-1:0]  fx_ext, fy_ext, pitch_ext, addr_calc;

   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [COLOR_BITS-1:0] pcolor_ff, pcolor_in;
   logic                  last_ff, last_in;

   always_comb begin
      dx      = {1'b0, x_end} - {1'b0, x_start};
      dy      = {1'b0, y_end} - {1'b0, y_start};
      adx     = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ady     = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      major_x = (adx >= ady);
      if (major_x) begin
         len       = {1'b0, adx} + (COORD_BITS+1)'(1);
         minor_mag = {1'b0, ady} + (COORD_BITS+1)'(1);
      end else begin
         len       = {1'b0, ady} + (COORD_BITS+1)'(1);
         minor_mag = {1'b0, adx} + (COORD_BITS+1)'(1);
      end
   end

   // restoring division, one quotient bit per cycle, integer bit first
   always_comb begin
      rem_ge  = (rem_ff >= {1'b0, den_ff});
      rem_sub = rem_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
   end

   always_comb begin
      major_step = major_neg_ff ? STEP_BITS'(-{2'b01, {FRAC_BITS{1'b0}}})
                                : {2'b01, {FRAC_BITS{1'b0}}};
      minor_step = minor_neg_ff ? STEP_BITS'(-{1'b0, quo_ff}) : {1'b0, quo_ff};
      step_x     = major_x_ff ? major_step : minor_step;
      step_y     = major_x_ff ? minor_step : major_step;
   end

   always_comb begin
      fx        = acc_x_ff[ACC_BITS-1:FRAC_BITS];
      fy        = acc_y_ff[ACC_BITS-1:FRAC_BITS];
      fx_ext    = {{(ADDR_BITS-FLR_BITS){fx[FLR_BITS-1]}}, fx};
      fy_ext    = {{(ADDR_BITS-FLR_BITS){fy[FLR_BITS-1]}}, fy};
      pitch_ext = {{(ADDR_BITS-PITCH_BITS){1'b0}}, pitch_ff};
      addr_calc = fy_ext * pitch_ext + fx_ext;
   end

   always_comb begin
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      left_in      = left_ff;
      pitch_in     = pitch_ff;
      color_in     = color_ff;
      major_x_in   = major_x_ff;
      major_neg_in = major_neg_ff;
      minor_neg_in = minor_neg_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      addr_in      = addr_ff;
      pcolor_in    = pcolor_ff;
      last_in      = last_ff;
      if (cmd.load) begin
         acc_x_in     = {2'b00, x_start, {FRAC_BITS{1'b0}}};
         acc_y_in     = {2'b00, y_start, {FRAC_BITS{1'b0}}};
         left_in      = len;
         pitch_in     = row_pitch;
         color_in     = color;
         major_x_in   = major_x;
         major_neg_in = major_x ? dx[COORD_BITS] : dy[COORD_BITS];
         minor_neg_in = major_x ? dy[COORD_BITS] : dx[COORD_BITS];
         den_in       = len;
         rem_in       = {1'b0, minor_mag};
         quo_in       = '0;
      end
      if (cmd.div_step) begin
         rem_in = {rem_sub[COORD_BITS:0], 1'b0};
         quo_in = {quo_ff[FRAC_BITS-1:0], rem_ge};
      end
      if (cmd.emit) begin
         addr_in   = addr_calc;
         pcolor_in = color_ff;
         last_in   = (left_ff == (COORD_BITS+1)'(1));
         acc_x_in  = acc_x_ff + {{(ACC_BITS-STEP_BITS){step_x[STEP_BITS-1]}}, step_x};
         acc_y_in  = acc_y_ff + {{(ACC_BITS-STEP_BITS){step_y[STEP_BITS-1]}}, step_y};
         left_in   = left_ff - (COORD_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         pitch_ff <= PITCH_RESET;
      end else begin
         left_ff  <= left_in;
         pitch_ff <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_x_ff     <= acc_x_in;
      acc_y_ff     <= acc_y_in;
      color_ff     <= color_in;
      major_x_ff   <= major_x_in;
      major_neg_ff <= major_neg_in;
      minor_neg_ff <= minor_neg_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      addr_ff      <= addr_in;
      pcolor_ff    <= pcolor_in;
      last_ff      <= last_in;
   end

   assign status.line_active = (left_ff != '0);
   assign pixel_address      = addr_ff;
   assign pixel_color        = pcolor_ff;
   assign last_pixel         = last_ff;

endmodule

@@ rtl/fixed_point_dda_line_drawer.sv @@
// Fixed-point DDA line drawer. A start request (tuser low) latches both
// endpoints, the color and the row pitch and gives no pixel; the block then
// runs a restoring divider to form the minor-axis step with req_tready low.
// A step request (tuser high) emits the next pixel address floor(y)*pitch
// plus floor(x) (modulo 2^20) with the color, tlast on the final pixel; a
// step with no line active is taken and dropped. Step requests are accepted
// every cycle while the result register is free or being drained.
module fixed_point_dda_line_drawer #(
   parameter  int COORD_BITS    = 10,
   parameter  int FRAC_BITS     = 10,
   localparam int REQ_DATA_BITS =
      ((4 * COORD_BITS + fpdda_pkg::COLOR_BITS + fpdda_pkg::PITCH_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS =
      ((fpdda_pkg::ADDR_BITS + fpdda_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // x_start, y_start, x_end, y_end, color, row_pitch
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // action
   input  logic [0:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pixel_address, pixel_color
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);
   import fpdda_pkg::*;

   localparam int C0 = 0;
   localparam int C1 = COORD_BITS;
   localparam int C2 = 2 * COORD_BITS;
   localparam int C3 = 3 * COORD_BITS;
   localparam int CL = 4 * COORD_BITS;
   localparam int PL = CL + COLOR_BITS;

   ctrl_cmd_type          cmd;
   status_type            status;
   logic [ADDR_BITS-1:0]  pixel_address;
   logic [COLOR_BITS-1:0] pixel_color;

   fpdda_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fpdda_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .x_start       (req_tdata[C1-1:C0]),
      .y_start       (req_tdata[C2-1:C1]),
      .x_end         (req_tdata[C3-1:C2]),
      .y_end         (req_tdata[CL-1:C3]),
      .color         (req_tdata[PL-1:CL]),
      .row_pitch     (req_tdata[PL+PITCH_BITS-1:PL]),
      .status        (status),
      .pixel_address (pixel_address),
      .pixel_color   (pixel_color),
      .last_pixel    (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_BITS'({pixel_color, pixel_address});

endmodule
